>>> rtl/qfp_pkg.sv
// qfp_pkg: transaction structs, field codes and verdict codes for the query frame parser
// no dependencies; imported by every module of the parser

package qfp_pkg;

  // field codes carried in field_id
  localparam logic [4:0] FLD_TEXT_LEN  = 5'd0;
  localparam logic [4:0] FLD_TEXT      = 5'd1;
  localparam logic [4:0] FLD_KIND      = 5'd2;
  localparam logic [4:0] FLD_TABLE_LEN = 5'd3;
  localparam logic [4:0] FLD_TABLE     = 5'd4;
  localparam logic [4:0] FLD_PART_FLAG = 5'd5;
  localparam logic [4:0] FLD_PARTITION = 5'd6;
  localparam logic [4:0] FLD_AGG_FLAG  = 5'd7;
  localparam logic [4:0] FLD_HOP_COUNT = 5'd8;
  localparam logic [4:0] FLD_HOP_LEN   = 5'd9;
  localparam logic [4:0] FLD_HOP_TEXT  = 5'd10;
  localparam logic [4:0] FLD_BUDGET    = 5'd11;
  localparam logic [4:0] FLD_STATUS    = 5'd12;
  localparam logic [4:0] FLD_PAY_LEN   = 5'd13;
  localparam logic [4:0] FLD_PAYLOAD   = 5'd14;
  localparam logic [4:0] FLD_ELAPSED   = 5'd15;
  localparam logic [4:0] FLD_DISCARD   = 5'd16;

  // verdict codes; the error codes share the same values
  localparam logic [2:0] VERDICT_PENDING  = 3'd0;
  localparam logic [2:0] VERDICT_ACCEPTED = 3'd1;
  localparam logic [2:0] VERDICT_TRUNC    = 3'd2;
  localparam logic [2:0] VERDICT_RANGE    = 3'd3;
  localparam logic [2:0] VERDICT_TRAILING = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MESSAGE_TYPE = 2'd0;
  localparam logic [1:0] REG_MAX_KIND     = 2'd1;
  localparam logic [1:0] REG_MAX_STATUS   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [7:0]  byte_value;
    logic [31:0] hop_number;
    logic        message_end;
    logic [2:0]  verdict;
  } out_t;

  typedef struct packed {
    logic       message_type;
    logic [7:0] max_kind;
    logic [7:0] max_status;
  } cfg_t;

endpackage

>>> rtl/qfp_parser.sv
// qfp_parser: per-byte parse state and field tagging, one byte per cycle while fire is high
// depends on qfp_pkg for the transaction structs and codes

module qfp_parser import qfp_pkg::*; #(
  parameter int LEN_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  in_t  in_data,
  input  cfg_t cfg,
  output out_t result
);

  typedef enum logic [4:0] {
    PH_TEXT_LEN  = 5'd0,
    PH_TEXT      = 5'd1,
    PH_KIND      = 5'd2,
    PH_TABLE_LEN = 5'd3,
    PH_TABLE     = 5'd4,
    PH_PART_FLAG = 5'd5,
    PH_PARTITION = 5'd6,
    PH_AGG_FLAG  = 5'd7,
    PH_HOP_COUNT = 5'd8,
    PH_HOP_LEN   = 5'd9,
    PH_HOP_TEXT  = 5'd10,
    PH_BUDGET    = 5'd11,
    PH_STATUS    = 5'd12,
    PH_PAY_LEN   = 5'd13,
    PH_PAYLOAD   = 5'd14,
    PH_ELAPSED   = 5'd15,
    PH_DONE      = 5'd16,
    PH_ERROR     = 5'd17,
    PH_START     = 5'd18
  } phase_t;

  phase_t               phase, phase_next;
  logic [2:0]           fixed_count, fixed_count_next;
  logic [31:0]          accum, accum_next;
  logic [LEN_WIDTH-1:0] text_left, text_left_next;
  logic [31:0]          hops_left, hops_left_next;
  logic [31:0]          hop_index, hop_index_next;
  logic [2:0]           err, err_next;

  phase_t      ph, text_phase, done_phase;
  logic        take, take8, take_len, take_count, text_byte, finish_text, fixed_done;
  logic [31:0] shifted;
  logic [63:0] len_wide;
  logic [7:0]  b;

  assign b        = in_data.data_byte;
  assign shifted  = {accum[23:0], b};
  assign len_wide = {32'd0, shifted} >> LEN_WIDTH;

  always_comb begin
    phase_next       = phase;
    fixed_count_next = fixed_count;
    accum_next       = accum;
    text_left_next   = text_left;
    hops_left_next   = hops_left;
    hop_index_next   = hop_index;
    err_next         = err;
    take             = 1'b0;
    take8            = 1'b0;
    take_len         = 1'b0;
    take_count       = 1'b0;
    text_byte        = 1'b0;
    finish_text      = 1'b0;
    text_phase       = PH_TEXT;
    done_phase       = PH_DONE;
    result.field_id    = FLD_DISCARD;
    result.byte_value  = b;
    result.hop_number  = 32'd0;
    result.message_end = in_data.final_byte;
    result.verdict     = VERDICT_PENDING;

    // message type is sampled on the first byte only
    if (phase == PH_START) begin
      ph = cfg.message_type ? PH_STATUS : PH_TEXT_LEN;
    end else begin
      ph = phase;
    end
    phase_next = ph;

    case (ph)
      PH_TEXT_LEN: begin
        result.field_id = FLD_TEXT_LEN;
        take = 1'b1; take_len = 1'b1; text_phase = PH_TEXT;
      end
      PH_TABLE_LEN: begin
        result.field_id = FLD_TABLE_LEN;
        take = 1'b1; take_len = 1'b1; text_phase = PH_TABLE;
      end
      PH_HOP_LEN: begin
        result.field_id   = FLD_HOP_LEN;
        result.hop_number = hop_index;
        take = 1'b1; take_len = 1'b1; text_phase = PH_HOP_TEXT;
      end
      PH_PAY_LEN: begin
        result.field_id = FLD_PAY_LEN;
        take = 1'b1; take_len = 1'b1; text_phase = PH_PAYLOAD;
      end
      PH_TEXT: begin
        result.field_id = FLD_TEXT;
        text_byte = 1'b1; text_phase = PH_TEXT;
      end
      PH_TABLE: begin
        result.field_id = FLD_TABLE;
        text_byte = 1'b1; text_phase = PH_TABLE;
      end
      PH_HOP_TEXT: begin
        result.field_id   = FLD_HOP_TEXT;
        result.hop_number = hop_index;
        text_byte = 1'b1; text_phase = PH_HOP_TEXT;
      end
      PH_PAYLOAD: begin
        result.field_id = FLD_PAYLOAD;
        text_byte = 1'b1; text_phase = PH_PAYLOAD;
      end
      PH_KIND: begin
        result.field_id = FLD_KIND;
        if (b > cfg.max_kind) begin
          err_next = VERDICT_RANGE; phase_next = PH_ERROR;
        end else begin
          phase_next = PH_TABLE_LEN;
        end
      end
      PH_PART_FLAG: begin
        result.field_id = FLD_PART_FLAG;
        phase_next = (b != 8'd0) ? PH_PARTITION : PH_AGG_FLAG;
      end
      PH_PARTITION: begin
        result.field_id = FLD_PARTITION;
        take = 1'b1; done_phase = PH_AGG_FLAG;
      end
      PH_AGG_FLAG: begin
        result.field_id = FLD_AGG_FLAG;
        phase_next = PH_HOP_COUNT;
      end
      PH_HOP_COUNT: begin
        result.field_id = FLD_HOP_COUNT;
        take = 1'b1; take_count = 1'b1;
      end
      PH_BUDGET: begin
        result.field_id = FLD_BUDGET;
        take = 1'b1; done_phase = PH_DONE;
      end
      PH_STATUS: begin
        result.field_id = FLD_STATUS;
        if (b > cfg.max_status) begin
          err_next = VERDICT_RANGE; phase_next = PH_ERROR;
        end else begin
          phase_next = PH_PAY_LEN;
        end
      end
      PH_ELAPSED: begin
        result.field_id = FLD_ELAPSED;
        take = 1'b1; take8 = 1'b1; done_phase = PH_DONE;
      end
      PH_DONE: begin
        // a byte past a complete frame
        err_next = VERDICT_TRAILING; phase_next = PH_ERROR;
      end
      default: begin
      end
    endcase

    // big-endian fixed-width numbers, four bytes or eight for elapsed
    fixed_done = take8 ? (fixed_count == 3'd7) : (fixed_count >= 3'd3);
    if (take) begin
      accum_next = shifted;
      if (fixed_done) begin
        fixed_count_next = 3'd0;
        accum_next       = 32'd0;
        if (take_len) begin
          if (len_wide != 64'd0) begin
            err_next = VERDICT_RANGE; phase_next = PH_ERROR;
          end else begin
            text_left_next = shifted[LEN_WIDTH-1:0];
            if (shifted != 32'd0) begin
              phase_next = text_phase;
            end else begin
              finish_text = 1'b1;
            end
          end
        end else if (take_count) begin
          hops_left_next = shifted;
          hop_index_next = 32'd0;
          phase_next     = (shifted != 32'd0) ? PH_HOP_LEN : PH_BUDGET;
        end else begin
          phase_next = done_phase;
        end
      end else begin
        fixed_count_next = fixed_count + 3'd1;
      end
    end

    if (text_byte) begin
      text_left_next = text_left - LEN_WIDTH'(1);
      if (text_left == LEN_WIDTH'(1)) begin
        finish_text = 1'b1;
      end
    end

    if (finish_text) begin
      case (text_phase)
        PH_TEXT:  phase_next = PH_KIND;
        PH_TABLE: phase_next = PH_PART_FLAG;
        PH_HOP_TEXT: begin
          hops_left_next = hops_left - 32'd1;
          hop_index_next = hop_index + 32'd1;
          phase_next     = (hops_left != 32'd1) ? PH_HOP_LEN : PH_BUDGET;
        end
        default: phase_next = PH_ELAPSED;
      endcase
    end

    // verdict on the final byte, then back to the start of a message
    if (in_data.final_byte) begin
      if (err_next != VERDICT_PENDING) begin
        result.verdict = err_next;
      end else if (phase_next == PH_DONE) begin
        result.verdict = VERDICT_ACCEPTED;
      end else begin
        result.verdict = VERDICT_TRUNC;
      end
      phase_next       = PH_START;
      fixed_count_next = 3'd0;
      accum_next       = 32'd0;
      text_left_next   = '0;
      hops_left_next   = 32'd0;
      hop_index_next   = 32'd0;
      err_next         = VERDICT_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      fixed_count <= 3'd0;
      accum       <= 32'd0;
      text_left   <= '0;
      hops_left   <= 32'd0;
      hop_index   <= 32'd0;
      err         <= VERDICT_PENDING;
    end else if (fire) begin
      phase       <= phase_next;
      fixed_count <= fixed_count_next;
      accum       <= accum_next;
      text_left   <= text_left_next;
      hops_left   <= hops_left_next;
      hop_index   <= hop_index_next;
      err         <= err_next;
    end
  end

endmodule

>>> rtl/qfp_out_buf.sv
// qfp_out_buf: result register with a skid stage toward the output channel
// depends on qfp_pkg for the result struct

module qfp_out_buf import qfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic full,
  output logic out_valid,
  output out_t out_data,
  input  logic out_stall
);

  logic skid_valid;
  out_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (push) begin
          out_valid <= 1'b1;
          out_data  <= push_data;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule

>>> rtl/query_frame_parser.sv
// query_frame_parser: top level with configuration registers, parser and output buffer
// depends on qfp_pkg, qfp_parser and qfp_out_buf

// Streaming frame parser. Each input transaction carries one message byte and a flag on
// the last byte; each produces exactly one output transaction with the byte, the number of
// the field it belongs to, the hop index for hop fields, and on the final byte the verdict
// (accepted, truncated, value out of range, trailing bytes). One byte is taken every cycle
// while input stall is low. Each result is registered into the output register, or into a
// one-entry skid stage while the output is held; input stall rises only when both are full.
// Configuration (message type, largest kind, largest status) is written through the plain
// write port, by the user only while no message is in flight; the block does not enforce
// this. Message type is sampled on the first byte of each message.

module query_frame_parser import qfp_pkg::*; #(
  parameter int LEN_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  in_t        in_data,
  output logic       in_stall,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       out_stall,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic in_fire;
  out_t result;

  // a byte moves in when the skid stage has room
  assign in_fire = in_valid && !in_stall;

  // configuration registers; writes past the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.message_type <= 1'b0;
      cfg.max_kind     <= 8'hff;
      cfg.max_status   <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MESSAGE_TYPE: cfg.message_type <= cfg_data[0];
        REG_MAX_KIND:     cfg.max_kind     <= cfg_data;
        REG_MAX_STATUS:   cfg.max_status   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // parse state and per-byte tagging
  qfp_parser #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .in_data (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // result register plus skid stage
  qfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // skid stage fills only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid stage full while output register empty");

  // a verdict is given on the final byte and only there
  a_verdict_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.message_end == (out_data.verdict != VERDICT_PENDING)))
    else $error("verdict and message end disagree");

  // hop index only travels with hop fields
  a_hop_number_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.field_id != FLD_HOP_LEN && out_data.field_id != FLD_HOP_TEXT)
      |-> out_data.hop_number == 32'd0)
    else $error("hop number set outside hop fields");

  // an accepted byte with room downstream shows up next cycle
  a_byte_latency: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !(out_valid && out_stall)) |=> out_valid)
    else $error("accepted transaction did not reach the output");

endmodule

>>> tb/sv/field_tag_check_pkg.sv
// field_tag_check_pkg: scoreboard class that predicts the field tag of every message byte
// depends on qfp_pkg for the transaction structs, field, verdict and register codes

package field_tag_check_pkg;
  import qfp_pkg::*;

  class field_tag_scoreboard;
    // parse positions; the first sixteen follow the field code order
    typedef enum logic [4:0] {
      P_TEXT_LEN, P_TEXT, P_KIND, P_TABLE_LEN, P_TABLE, P_PART_FLAG, P_PARTITION,
      P_AGG_FLAG, P_HOP_COUNT, P_HOP_LEN, P_HOP_TEXT, P_BUDGET, P_STATUS, P_PAY_LEN,
      P_PAYLOAD, P_ELAPSED, P_DONE, P_ERROR, P_IDLE
    } phase_e;

    int unsigned len_bits = 32;

    logic        response_mode;
    logic [7:0]  kind_limit;
    logic [7:0]  status_limit;

    phase_e      phase;
    int unsigned byte_cnt;
    logic [31:0] accum;
    logic [31:0] text_left;
    logic [31:0] hops_left;
    logic [31:0] hop_idx;
    logic [2:0]  err_code;

    out_t        expected_tags[$];
    int unsigned mismatch_count;

    function new();
      response_mode  = 1'b0;
      kind_limit     = 8'hFF;
      status_limit   = 8'hFF;
      mismatch_count = 0;
      start_message();
    endfunction

    function void start_message();
      phase     = P_IDLE;
      byte_cnt  = 0;
      accum     = '0;
      text_left = '0;
      hops_left = '0;
      hop_idx   = '0;
      err_code  = VERDICT_PENDING;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_MESSAGE_TYPE: response_mode = val[0];
        REG_MAX_KIND:     kind_limit = val;
        REG_MAX_STATUS:   status_limit = val;
        default: ;
      endcase
    endfunction

    // big-endian shift; true once n bytes are in
    function bit shift_in(logic [7:0] b, int unsigned n);
      accum = {accum[23:0], b};
      if (byte_cnt + 1 >= n) begin
        byte_cnt = 0;
        return 1'b1;
      end
      byte_cnt++;
      return 1'b0;
    endfunction

    function phase_e next_after_text(phase_e text_phase);
      case (text_phase)
        P_TEXT:  return P_KIND;
        P_TABLE: return P_PART_FLAG;
        P_HOP_TEXT: begin
          hops_left--;
          hop_idx++;
          if (hops_left != 0) return P_HOP_LEN;
          return P_BUDGET;
        end
        default: return P_ELAPSED;
      endcase
    endfunction

    function void abort(logic [2:0] code);
      err_code = code;
      phase = P_ERROR;
    endfunction

    function void note_byte(in_t item);
      out_t        tag;
      logic [31:0] len;
      logic [7:0]  b;
      b = item.data_byte;
      tag = '0;
      tag.field_id = FLD_DISCARD;
      tag.byte_value = b;
      tag.message_end = item.final_byte;
      tag.verdict = VERDICT_PENDING;
      // mode is latched on the first byte of a message
      if (phase == P_IDLE) phase = response_mode ? P_STATUS : P_TEXT_LEN;
      case (phase)
        P_TEXT_LEN, P_TABLE_LEN, P_HOP_LEN, P_PAY_LEN: begin
          tag.field_id = phase;
          if (phase == P_HOP_LEN) tag.hop_number = hop_idx;
          if (shift_in(b, 4)) begin
            len = accum;
            accum = '0;
            if ((len >> len_bits) != 0) begin
              abort(VERDICT_RANGE);
            end else begin
              text_left = len;
              if (len != 0) phase = phase_e'(phase + 5'd1);
              else phase = next_after_text(phase_e'(phase + 5'd1));
            end
          end
        end
        P_TEXT, P_TABLE, P_HOP_TEXT, P_PAYLOAD: begin
          tag.field_id = phase;
          if (phase == P_HOP_TEXT) tag.hop_number = hop_idx;
          text_left--;
          if (text_left == 0) phase = next_after_text(phase);
        end
        P_KIND: begin
          tag.field_id = phase;
          if (b > kind_limit) abort(VERDICT_RANGE);
          else phase = P_TABLE_LEN;
        end
        P_PART_FLAG: begin
          tag.field_id = phase;
          phase = (b != 0) ? P_PARTITION : P_AGG_FLAG;
        end
        P_PARTITION: begin
          tag.field_id = phase;
          if (shift_in(b, 4)) begin
            accum = '0;
            phase = P_AGG_FLAG;
          end
        end
        P_AGG_FLAG: begin
          tag.field_id = phase;
          phase = P_HOP_COUNT;
        end
        P_HOP_COUNT: begin
          tag.field_id = phase;
          if (shift_in(b, 4)) begin
            hops_left = accum;
            accum = '0;
            hop_idx = '0;
            phase = (hops_left != 0) ? P_HOP_LEN : P_BUDGET;
          end
        end
        P_BUDGET: begin
          tag.field_id = phase;
          if (shift_in(b, 4)) begin
            accum = '0;
            phase = P_DONE;
          end
        end
        P_STATUS: begin
          tag.field_id = phase;
          if (b > status_limit) abort(VERDICT_RANGE);
          else phase = P_PAY_LEN;
        end
        P_ELAPSED: begin
          tag.field_id = phase;
          if (shift_in(b, 8)) begin
            accum = '0;
            phase = P_DONE;
          end
        end
        P_DONE: abort(VERDICT_TRAILING);
        default: ;
      endcase
      if (item.final_byte) begin
        if (err_code != VERDICT_PENDING) tag.verdict = err_code;
        else tag.verdict = (phase == P_DONE) ? VERDICT_ACCEPTED : VERDICT_TRUNC;
        start_message();
      end
      expected_tags = {expected_tags, tag};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_tag(out_t got);
      out_t want;
      if (expected_tags.size() == 0) begin
        $error("result with no byte waiting: field_id %0d, byte_value %0d",
               got.field_id, got.byte_value);
        mismatch_count++;
        return;
      end
      want = expected_tags.pop_front();
      compare_field("field_id", want.field_id, got.field_id);
      compare_field("byte_value", want.byte_value, got.byte_value);
      compare_field("hop_number", want.hop_number, got.hop_number);
      compare_field("message_end", want.message_end, got.message_end);
      compare_field("verdict", want.verdict, got.verdict);
    endfunction

    function int unsigned pending();
      return expected_tags.size();
    endfunction
  endclass

endpackage

>>> tb/sv/query_frame_parser_tb.sv
// query_frame_parser_tb: drives message bytes through the frame parser and checks every tag
// depends on qfp_pkg, field_tag_check_pkg and the query_frame_parser rtl

module query_frame_parser_tb;
  import qfp_pkg::*;
  import field_tag_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 8;
  localparam int BYTES_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TIMEOUT_NS      = 5_000_000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  in_t        in_data;
  logic       in_stall;
  logic       out_valid;
  out_t       out_data;
  logic       out_stall;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  field_tag_scoreboard sb;

  // stimulus side copy of the register settings, used to shape frames
  logic       cur_message_type = 1'b0;
  logic [7:0] cur_max_kind = 8'hFF;
  logic [7:0] cur_max_status = 8'hFF;

  // random idling on both sides; cleared for the last phase of the run
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_bytes[$];

  query_frame_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall bursts, changed only at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // every accepted output transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_tag(out_data);
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    in_t item;
    item.data_byte = b;
    item.final_byte = last;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(item);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // wait for every predicted tag, then let the pipeline settle before any register write
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes are back to back; the caller lowers the enable after the last one
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    sb.set_register(idx, val);
  endtask

  function automatic logic [7:0] extreme_limit(int sel);
    case (sel % 4)
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  task automatic configure(int ph);
    cur_message_type = ph[0];
    cur_max_kind = extreme_limit(ph / 2);
    cur_max_status = extreme_limit(ph / 2 + 1);
    write_reg(REG_MESSAGE_TYPE, {7'd0, cur_message_type});
    write_reg(REG_MAX_KIND, cur_max_kind);
    write_reg(REG_MAX_STATUS, cur_max_status);
    cfg_we <= 1'b0;
  endtask

  // frame building: big-endian words and length-prefixed texts of mostly small size
  function automatic void add_byte(logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  function automatic void add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 9))
      0, 1: return 0;
      9: return $urandom_range(7, 30);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic void add_text();
    int unsigned n;
    n = pick_len();
    add_word(n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  // mostly within the limit, now and then any value to hit the range check
  function automatic logic [7:0] pick_limited(logic [7:0] lim);
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, lim));
  endfunction

  function automatic void build_request();
    int unsigned hops;
    add_text();
    add_byte(pick_limited(cur_max_kind));
    add_text();
    // partition flag: zero skips the partition, any other value brings one
    if ($urandom_range(0, 1)) begin
      add_byte(8'h00);
    end else begin
      add_byte(8'($urandom_range(1, 255)));
      add_word($urandom);
    end
    add_byte(8'($urandom));
    hops = $urandom_range(0, 3);
    add_word(hops);
    repeat (hops) add_text();
    add_word($urandom);
  endfunction

  function automatic void build_response();
    add_byte(pick_limited(cur_max_status));
    add_text();
    add_word($urandom);
    add_word($urandom);
  endfunction

  // mostly well-formed frames; the rest truncated, padded, corrupted or pure noise
  function automatic void build_message();
    int unsigned keep;
    frame_bytes.delete();
    if (cur_message_type) build_response();
    else build_request();
    case ($urandom_range(0, 11))
      0: begin
        keep = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      1: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      2: begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      end
      3: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
      default: ;
    endcase
  endfunction

  initial begin
    int unsigned phase_start;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MESSAGE_TYPE;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // single-byte messages at both byte extremes: truncated in the first length field
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    // shortest request: empty texts, no partition, zero hops, largest kind, then one
    // trailing byte after the complete frame
    frame_bytes.delete();
    add_word(32'd0);
    add_byte(8'hFF);
    add_word(32'd0);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_word(32'd0);
    add_word(32'hFFFF_FFFF);
    add_byte(8'h5A);
    send_frame();
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      configure(ph);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        build_message();
        send_frame();
      end
      drain();
    end

    if (sb.mismatch_count == 0) begin
      $display("query_frame_parser regression: pass");
    end else begin
      $display("query_frame_parser regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("query_frame_parser regression: fail");
    $finish;
  end

endmodule
